// ----- src/led_grayscale_frame_packer_core_defines.svh -----
// Assertion macros for the LED grayscale frame packer.
// Included by modules that check their own sequencing; expects clk and rst_n in scope.
`ifndef LED_GRAYSCALE_FRAME_PACKER_CORE_DEFINES_SVH
`define LED_GRAYSCALE_FRAME_PACKER_CORE_DEFINES_SVH

// same-cycle implication
`define LGFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lgfp_pkg.sv -----
// Shared types, constants and microcode ROM for the LED grayscale frame packer.
// No dependencies; used by the channel interfaces, the core, the frame checker and the testbench.
`timescale 1ns / 1ps

package lgfp_pkg;

  localparam int LEVEL_W  = 8;
  localparam int BRIGHT_W = 7;
  localparam int VAL_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 3 * LEVEL_W;
  localparam int PROD_W   = LEVEL_W + BRIGHT_W;   // level * brightness
  localparam int NUM_W    = PROD_W + 2;           // times 3 or 4
  localparam int DIV_K_W  = 20;
  localparam int MUL_W    = NUM_W + DIV_K_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

  // x*16/100 == x*4/25, x*48/400 == x*3/25; divide by 25 via reciprocal
  localparam int                 DIV_SH = 24;
  localparam logic [DIV_K_W-1:0] DIV_K  = 20'd671088;  // floor(2^24 / 25)
  localparam logic [NUM_W-1:0]   DIV_D  = 17'd25;

  localparam logic CMD_SET_COLOR = 1'b0;
  localparam logic CMD_UPDATE    = 1'b1;

  typedef logic [1:0] chan_t;
  localparam chan_t CH_BLUE  = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_RED   = 2'd2;

  typedef logic [1:0] bsel_t;
  localparam bsel_t BSEL_HI  = 2'd0;
  localparam bsel_t BSEL_MID = 2'd1;
  localparam bsel_t BSEL_LO  = 2'd2;

  typedef logic [1:0] cond_t;
  localparam cond_t C_NONE  = 2'd0;  // never true
  localparam cond_t C_IDLE  = 2'd1;  // no update request taken
  localparam cond_t C_HALF0 = 2'd2;  // first value of a pair just computed
  localparam cond_t C_MORE  = 2'd3;  // frame not finished

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_RD   = 4'd1;
  localparam step_t ST_PROD = 4'd2;
  localparam step_t ST_NUM  = 4'd3;
  localparam step_t ST_MUL  = 4'd4;
  localparam step_t ST_DIV  = 4'd5;
  localparam step_t ST_EB0  = 4'd6;
  localparam step_t ST_EB1  = 4'd7;
  localparam step_t ST_EB2  = 4'd8;

  typedef struct packed {
    logic  accept;
    logic  mem_rd;
    logic  ld_prod;
    logic  ld_num;
    logic  ld_mul;
    logic  ld_val;
    logic  emit;
    bsel_t bsel;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  function automatic uword_t lgfp_ucode(input step_t step);
    uword_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.accept = 1'b1; w.cond = C_IDLE; w.tgt_t = ST_IDLE; w.tgt_f = ST_RD;
      end
      ST_RD:   begin w.mem_rd  = 1'b1; w.tgt_f = ST_PROD; end
      ST_PROD: begin w.ld_prod = 1'b1; w.tgt_f = ST_NUM;  end
      ST_NUM:  begin w.ld_num  = 1'b1; w.tgt_f = ST_MUL;  end
      ST_MUL:  begin w.ld_mul  = 1'b1; w.tgt_f = ST_DIV;  end
      ST_DIV: begin
        w.ld_val = 1'b1; w.cond = C_HALF0; w.tgt_t = ST_RD; w.tgt_f = ST_EB0;
      end
      ST_EB0: begin w.emit = 1'b1; w.bsel = BSEL_HI;  w.tgt_f = ST_EB1; end
      ST_EB1: begin w.emit = 1'b1; w.bsel = BSEL_MID; w.tgt_f = ST_EB2; end
      ST_EB2: begin
        w.emit = 1'b1; w.bsel = BSEL_LO; w.cond = C_MORE;
        w.tgt_t = ST_RD; w.tgt_f = ST_IDLE;
      end
      default: begin w.tgt_f = ST_IDLE; end
    endcase
    return w;
  endfunction

endpackage

// ----- src/lgfp_channels.sv -----
// Valid/ready channel interfaces: command requests in, frame bytes out, brightness writes.
// Depends on lgfp_pkg for field widths.
`timescale 1ns / 1ps

interface lgfp_in_if import lgfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [2:0]          led_index;
  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  modport source (output valid, command, led_index, red_level, green_level, blue_level,
                  input ready);
  modport sink   (input valid, command, led_index, red_level, green_level, blue_level,
                  output ready);
endinterface

interface lgfp_out_if import lgfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface lgfp_cfg_if import lgfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness_percent;
  modport source (output valid, brightness_percent, input ready);
  modport sink   (input valid, brightness_percent, output ready);
endinterface

// ----- src/led_grayscale_frame_packer_core.sv -----
// LED grayscale frame packer core: color store, microcoded scale/pack sequencer.
// Depends on lgfp_pkg, the lgfp channel interfaces and the assertion macro header.
//
// Stores an RGB color per LED (black after reset) and, on an update request, streams
// the packed 12-bit grayscale frame of (LED_COUNT/2)*9 bytes, last_byte set on the
// final one. In an update every 12-bit value passes the one shared scale-and-divide
// path in five microcode steps (color read, level*brightness, *3 or *4, reciprocal
// multiply, /25 correction), and each pair of values then takes three steps to emit
// its bytes. The color store resets through per-entry valid bits, so there is no
// clearing pass.
// Brightness writes above 100 saturate and must only be issued while the block is idle.
`timescale 1ns / 1ps

module led_grayscale_frame_packer_core import lgfp_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  lgfp_in_if.sink    in_ch,
  lgfp_out_if.source out_ch,
  lgfp_cfg_if.sink   cfg_ch
);

  `include "led_grayscale_frame_packer_core_defines.svh"

  localparam int LED_AW   = $clog2(LED_COUNT);
  localparam int LAST_LED = (LED_COUNT / 2) * 2 - 1;

  // sequencer
  step_t  step_r;
  step_t  step_nxt;
  uword_t cw;
  logic   cond_w;
  logic   stall_w;
  logic   emit_fire_w;
  logic   in_fire_w;
  logic   start_w;

  // counters
  logic [LED_AW-1:0] led_r;
  chan_t             chan_r;
  logic              half_r;
  logic              fin_r;

  // color store
  logic [COLOR_W-1:0] color_mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_r;
  logic [COLOR_W-1:0] rd_color_r;
  logic               rd_vld_r;
  logic [31:0]        wr_idx_w;
  logic               wr_en_w;

  // datapath
  logic [BRIGHT_W-1:0] bright_r;
  logic [LEVEL_W-1:0]  level_w;
  logic [PROD_W-1:0]   prod_r;
  logic [NUM_W-1:0]    num_r;
  logic [MUL_W-1:0]    mul_r;
  logic [VAL_W-1:0]    q_est_w;
  logic [NUM_W-1:0]    rem_w;
  logic [VAL_W-1:0]    q_w;
  logic [VAL_W-1:0]    a_r;
  logic [VAL_W-1:0]    b_r;
  logic [BYTE_W-1:0]   byte_w;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  assign cw          = lgfp_ucode(step_r);
  assign in_ch.ready = cw.accept;
  assign in_fire_w   = in_ch.valid && cw.accept;
  assign start_w     = in_fire_w && (in_ch.command == CMD_UPDATE);
  assign emit_fire_w = cw.emit && (!out_valid_r || out_ch.ready);
  assign stall_w     = cw.emit && !emit_fire_w;

  always_comb begin
    unique case (cw.cond)
      C_NONE:  cond_w = 1'b0;
      C_IDLE:  cond_w = !start_w;
      C_HALF0: cond_w = !half_r;
      C_MORE:  cond_w = !fin_r;
      default: cond_w = 1'b0;
    endcase
    step_nxt = cond_w ? cw.tgt_t : cw.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else if (!stall_w) begin
      step_r <= step_nxt;
    end
  end

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= '0;
    end else if (cfg_ch.valid) begin
      bright_r <= (cfg_ch.brightness_percent > BRIGHT_MAX) ? BRIGHT_MAX
                                                           : cfg_ch.brightness_percent;
    end
  end

  // color store writes and registered reads
  assign wr_idx_w = 32'(in_ch.led_index);
  assign wr_en_w  = in_fire_w && (in_ch.command == CMD_SET_COLOR)
                    && (wr_idx_w < 32'(LED_COUNT));

  always_ff @(posedge clk) begin
    if (wr_en_w) begin
      color_mem[wr_idx_w[LED_AW-1:0]] <= {in_ch.red_level, in_ch.green_level,
                                          in_ch.blue_level};
    end
    if (cw.mem_rd) begin
      rd_color_r <= color_mem[led_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en_w) begin
        vld_r[wr_idx_w[LED_AW-1:0]] <= 1'b1;
      end
      if (cw.mem_rd) begin
        rd_vld_r <= vld_r[led_r];
      end
    end
  end

  // channel select; unwritten entries read as black
  always_comb begin
    unique case (chan_r)
      CH_BLUE:  level_w = rd_color_r[LEVEL_W-1:0];
      CH_GREEN: level_w = rd_color_r[2*LEVEL_W-1:LEVEL_W];
      CH_RED:   level_w = rd_color_r[3*LEVEL_W-1:2*LEVEL_W];
      default:  level_w = '0;
    endcase
    if (!rd_vld_r) begin
      level_w = '0;
    end
  end

  // quotient estimate is exact or one low; one compare fixes it
  assign q_est_w = mul_r[DIV_SH +: VAL_W];
  assign rem_w   = num_r - NUM_W'(NUM_W'(q_est_w) * DIV_D);
  assign q_w     = (rem_w >= DIV_D) ? q_est_w + VAL_W'(1) : q_est_w;

  always_ff @(posedge clk) begin
    if (cw.ld_prod) begin
      prod_r <= PROD_W'({{BRIGHT_W{1'b0}}, level_w} * {{LEVEL_W{1'b0}}, bright_r});
    end
    if (cw.ld_num) begin
      num_r <= (chan_r == CH_BLUE) ? ({prod_r, 1'b0} + {1'b0, prod_r}) + NUM_W'(0)
                                   : {prod_r, 2'b00};
    end
    if (cw.ld_mul) begin
      mul_r <= MUL_W'(num_r) * MUL_W'(DIV_K);
    end
    if (cw.ld_val) begin
      if (!half_r) begin
        a_r <= q_w;
      end else begin
        b_r <= q_w;
      end
    end
  end

  // value walk: per LED blue, green, red
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r  <= '0;
      chan_r <= CH_BLUE;
      half_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (start_w) begin
      led_r  <= '0;
      chan_r <= CH_BLUE;
      half_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (cw.ld_val) begin
      half_r <= !half_r;
      if (chan_r == CH_RED) begin
        chan_r <= CH_BLUE;
        if (led_r == LED_AW'(LAST_LED)) begin
          led_r <= '0;
          fin_r <= 1'b1;
        end else begin
          led_r <= led_r + LED_AW'(1);
        end
      end else begin
        chan_r <= chan_r + chan_t'(1);
      end
    end
  end

  always_comb begin
    unique case (cw.bsel)
      BSEL_HI:  byte_w = a_r[VAL_W-1:4];
      BSEL_MID: byte_w = {a_r[3:0], b_r[VAL_W-1:8]};
      BSEL_LO:  byte_w = b_r[BYTE_W-1:0];
      default:  byte_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire_w) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire_w) begin
      out_byte_r <= byte_w;
      out_last_r <= (cw.bsel == BSEL_LO) && fin_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.last_byte  = out_last_r;

  `LGFP_ASSERT_NXT(a_start_clears, start_w,
    (step_r == ST_RD) && (led_r == '0) && (chan_r == CH_BLUE) && !fin_r && !half_r,
    "update request did not restart the value walk")
  `LGFP_ASSERT_IMP(a_emit_pair_ready, cw.emit, !half_r,
    "byte emitted while a value pair is half computed")
  `LGFP_ASSERT_NXT(a_last_ends_frame, emit_fire_w && (cw.bsel == BSEL_LO) && fin_r,
    (step_r == ST_IDLE) && out_valid_r && out_last_r,
    "final byte did not end the frame")
  `LGFP_ASSERT_IMP(a_bright_range, 1'b1, bright_r <= BRIGHT_MAX,
    "brightness register above saturation limit")

endmodule

// ----- sim/led_frame_checker.sv -----
// Frame checker for the LED grayscale frame packer: watches the request, byte and
// brightness channels, predicts every frame byte and compares. Depends on lgfp_pkg
// and the lgfp channel interfaces.
`timescale 1ns / 1ps

module led_frame_checker import lgfp_pkg::*; #(
  parameter int LED_COUNT = 8
) (
  input  logic clk,
  input  logic rst_n,
  lgfp_in_if   req_mon,
  lgfp_out_if  byte_mon,
  lgfp_cfg_if  cfg_mon,
  output int   bytes_due,
  output int   mismatch_count
);

  localparam int FRAME_BYTES = (LED_COUNT / 2) * 9;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_byte_t;

  logic [COLOR_W-1:0]  led_rgb [LED_COUNT];
  logic [BRIGHT_W-1:0] bright_pct;
  frame_byte_t         frame_bytes_due [$];

  initial bytes_due = 0;

  // red/green: level*pct*16/100, blue: level*pct*48/400, both truncated
  function automatic logic [VAL_W-1:0] scale_level(input logic [LEVEL_W-1:0] lvl,
                                                   input logic is_blue);
    int unsigned prod;
    prod = int'(lvl) * int'(bright_pct);
    if (is_blue) begin
      return VAL_W'((prod * 48) / 400);
    end
    return VAL_W'((prod * 16) / 100);
  endfunction

  function automatic void queue_frame();
    logic [VAL_W-1:0] vals [6];
    logic [COLOR_W-1:0] c;
    logic [VAL_W-1:0] a, b;
    logic [BYTE_W-1:0] bytes [3];
    frame_byte_t fb;
    int n;
    n = 0;
    for (int p = 0; p + 1 < LED_COUNT; p += 2) begin
      for (int led = 0; led < 2; led++) begin
        c = led_rgb[p + led];
        vals[led * 3 + 0] = scale_level(c[7:0], 1'b1);
        vals[led * 3 + 1] = scale_level(c[15:8], 1'b0);
        vals[led * 3 + 2] = scale_level(c[23:16], 1'b0);
      end
      for (int k = 0; k < 6; k += 2) begin
        a = vals[k];
        b = vals[k + 1];
        bytes[0] = a[11:4];
        bytes[1] = {a[3:0], b[11:8]};
        bytes[2] = b[7:0];
        for (int m = 0; m < 3; m++) begin
          fb.data = bytes[m];
          fb.last = (n == FRAME_BYTES - 1);
          frame_bytes_due.push_back(fb);
          n++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t exp_byte;
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) led_rgb[i] = '0;
      bright_pct = '0;
      frame_bytes_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        bright_pct = (cfg_mon.brightness_percent > BRIGHT_MAX) ? BRIGHT_MAX
                                                               : cfg_mon.brightness_percent;
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        if (req_mon.command == CMD_UPDATE) begin
          queue_frame();
        end else if (int'(req_mon.led_index) < LED_COUNT) begin
          led_rgb[req_mon.led_index] = {req_mon.red_level, req_mon.green_level,
                                        req_mon.blue_level};
        end
      end
      if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1) begin
        if (frame_bytes_due.size() == 0) begin
          $error("frame byte %0h with no frame request pending", byte_mon.frame_byte);
          mismatch_count++;
        end else begin
          exp_byte = frame_bytes_due.pop_front();
          if (byte_mon.frame_byte !== exp_byte.data) begin
            $error("frame_byte mismatch: expected %0h, actual %0h",
                   exp_byte.data, byte_mon.frame_byte);
            mismatch_count++;
          end
          if (byte_mon.last_byte !== exp_byte.last) begin
            $error("last_byte mismatch: expected %0b, actual %0b",
                   exp_byte.last, byte_mon.last_byte);
            mismatch_count++;
          end
        end
      end
    end
    bytes_due = frame_bytes_due.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the LED grayscale frame packer testbench: clock, reset, request and brightness
// stimulus, output backpressure and the verdict. Depends on lgfp_pkg, the lgfp channel
// interfaces, the packer core and led_frame_checker.
`timescale 1ns / 1ps

module testbench;
  import lgfp_pkg::*;

  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 8;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  bit   hold_taken = 1'b0;
  int   hold_left  = 0;
  int   bytes_due;
  int   mismatch_count;

  lgfp_in_if  req_if ();
  lgfp_out_if byte_if ();
  lgfp_cfg_if cfg_if ();

  led_grayscale_frame_packer_core #(.LED_COUNT(8)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (byte_if),
    .cfg_ch (cfg_if)
  );

  led_frame_checker #(.LED_COUNT(8)) frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (req_if),
    .byte_mon       (byte_if),
    .cfg_mon        (cfg_if),
    .bytes_due      (bytes_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_SET_COLOR;
    req_if.led_index = '0;
    req_if.red_level = '0;
    req_if.green_level = '0;
    req_if.blue_level = '0;
    byte_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.brightness_percent = '0;
  end

  always #6 clk = ~clk;

  initial begin
    #7_200_000;
    $display("Test completed with failures");
    $finish;
  end

  // byte receiver; one long hold-off when asked, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      byte_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      byte_if.ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_taken <= 1'b1;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // leaves valid high on return; caller lowers it when the burst ends
  task automatic send_req(input logic cmd, input logic [2:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.led_index <= idx;
    req_if.red_level <= r;
    req_if.green_level <= g;
    req_if.blue_level <= b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bytes_due != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // only called with the request channel quiet and all bytes out
  task automatic write_brightness(input logic [BRIGHT_W-1:0] pct);
    cfg_if.valid <= 1'b1;
    cfg_if.brightness_percent <= pct;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [BRIGHT_W-1:0] pick_brightness();
    case ($urandom_range(4))
      0: return '0;
      1: return BRIGHT_MAX;
      2: return BRIGHT_W'($urandom_range(127, 101));
      default: return BRIGHT_W'($urandom_range(100));
    endcase
  endfunction

  initial begin
    logic cmd;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // black frame at reset brightness; update fields are don't-care
    send_req(CMD_UPDATE, 3'd7, 8'hff, 8'hff, 8'hff);
    req_if.valid <= 1'b0;
    wait_drained();
    write_brightness(BRIGHT_MAX);
    send_req(CMD_SET_COLOR, 3'd0, 8'hff, 8'hff, 8'hff);
    send_req(CMD_SET_COLOR, 3'd1, 8'hff, 8'h00, 8'h00);
    send_req(CMD_SET_COLOR, 3'd2, 8'h00, 8'hff, 8'h00);
    send_req(CMD_SET_COLOR, 3'd3, 8'h00, 8'h00, 8'hff);
    send_req(CMD_SET_COLOR, 3'd4, 8'haa, 8'h55, 8'h80);
    send_req(CMD_SET_COLOR, 3'd5, 8'h01, 8'h02, 8'h03);
    send_req(CMD_SET_COLOR, 3'd6, 8'h7f, 8'h80, 8'hfe);
    send_req(CMD_SET_COLOR, 3'd7, 8'h00, 8'h00, 8'h00);
    send_req(CMD_UPDATE, 3'd0, 8'h00, 8'h00, 8'h00);
    req_if.valid <= 1'b0;
    wait_drained();
    // above-range writes saturate
    write_brightness(7'd127);
    send_req(CMD_SET_COLOR, 3'd7, 8'hff, 8'hff, 8'hff);
    send_req(CMD_UPDATE, 3'd2, 8'h5a, 8'ha5, 8'h3c);
    req_if.valid <= 1'b0;
    wait_drained();
    write_brightness(7'd101);
    send_req(CMD_UPDATE, 3'd5, 8'h00, 8'hff, 8'h00);
    req_if.valid <= 1'b0;
    wait_drained();
    write_brightness(7'd1);
    send_req(CMD_UPDATE, 3'd1, 8'h80, 8'h01, 8'hfe);
    req_if.valid <= 1'b0;
    wait_drained();
    write_brightness(7'd0);
    send_req(CMD_UPDATE, 3'd4, 8'hff, 8'h00, 8'hff);
    req_if.valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        wait_drained();
        write_brightness(pick_brightness());
        // with no idling, stall the byte side long enough to back up requests
        if (phase == 2 && chunk == 1) hold_req <= 1'b1;
        for (int n = 0; n < 26; n++) begin
          cmd = ($urandom_range(99) < 25) ? CMD_UPDATE : CMD_SET_COLOR;
          send_req(cmd, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        req_if.valid <= 1'b0;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
